@@ rtl/kdim_pkg.sv @@
// ----------------------------------------------------------------------------
// kdim_pkg
// Shared types and constants for the key to dense index map.
// ----------------------------------------------------------------------------
`default_nettype none

package kdim_pkg;

    localparam int KEY_W = 64;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    // Request opcodes (carried on tuser)
    localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
    localparam logic [OP_W-1:0] OP_REV   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
    localparam logic [ST_W-1:0] ST_UNASSIGNED = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_KEY_CHK,
        S_REV_RD,
        S_CLEAR,
        S_EMIT
    } t_state;

    // Which result word to build
    typedef enum logic [2:0] {
        RES_HIT,
        RES_NEW,
        RES_FULL,
        RES_REV,
        RES_BADIDX,
        RES_ZERO
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic  latch;
        logic  slot_rd;
        logic  insert;
        logic  key_rd;
        logic  key_rd_idx;
        logic  advance;
        logic  clr_wr;
        logic  count_clear;
        logic  load_out;
        t_kind kind;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_empty;
        logic key_match;
        logic table_full;
        logic probe_last;
        logic idx_ok;
        logic clr_last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/key_to_dense_index_map.sv @@
// ----------------------------------------------------------------------------
// key_to_dense_index_map
// Two-way map between 64-bit keys and dense indices assigned in order.
// ----------------------------------------------------------------------------
// A map request (tuser 0) returns the index of a key, assigning the next free
// index on first sight; a reverse request (tuser 1) returns the key held at an
// index; a clear request (tuser 2) empties the map. Keys are found through an
// open-addressed slot table with linear probing, held in single-port memory.
// A map request reads its home slot, then for each occupied slot reads the
// key that it names and moves on to the next slot on a mismatch (slot read,
// then key read through the same ports). A reverse request reads the key
// store unless the index is not assigned yet. A clear sweeps all HASH_SLOTS
// slots, one slot written per cycle. After reset the same sweep runs before
// the first word is accepted. One request is in flight at a time; a finished
// result waits in the output register while the next request is taken.
`default_nettype none

module key_to_dense_index_map
    import kdim_pkg::*;
#(
    parameter int  CAPACITY   = 1024,
    parameter int  HASH_SLOTS = 2048,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_TW      = ((KEY_W + IDX_W + 7) / 8) * 8,
    localparam int OUT_TW     = ((IDX_W + KEY_W + 1 + ST_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // key, index
    input  wire logic [IN_TW-1:0]  s_axis_tdata,
    // opcode
    input  wire logic [OP_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // dense_index, sparse_key, was_new, status, entry_count
    output logic [OUT_TW-1:0]      m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    kdim_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_op            (s_axis_tuser),
        .i_sts           (w_sts),
        .o_s_axis_tready (s_axis_tready),
        .o_cmd           (w_cmd)
    );

    // Storage and result path
    kdim_dp #(
        .CAPACITY   (CAPACITY),
        .HASH_SLOTS (HASH_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tready (m_axis_tready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_m_axis_tvalid (m_axis_tvalid),
        .o_m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/kdim_ctrl.sv @@
// ----------------------------------------------------------------------------
// kdim_ctrl
// Sequencer: probe loop, reverse read, clear sweep and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module kdim_ctrl
    import kdim_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_sts            i_sts,
    output logic                 o_s_axis_tready,
    output t_cmd                 o_cmd
);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    // State and pending result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_kind  <= RES_ZERO;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        o_cmd.kind      = r_kind;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.latch = 1'b1;
                    case (i_op)
                        OP_MAP:   n_state = S_SLOT_RD;
                        OP_REV: begin
                            if (i_sts.idx_ok) begin
                                n_state = S_REV_RD;
                            end else begin
                                n_kind  = RES_BADIDX;
                                n_state = S_EMIT;
                            end
                        end
                        OP_CLEAR: n_state = S_CLEAR;
                        default: begin
                            n_kind  = RES_ZERO;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SLOT_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (!i_sts.slot_empty) begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = S_KEY_CHK;
                end else if (i_sts.table_full) begin
                    n_kind  = RES_FULL;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_kind       = RES_NEW;
                    n_state      = S_EMIT;
                end
            end
            S_KEY_CHK: begin
                if (i_sts.key_match) begin
                    n_kind  = RES_HIT;
                    n_state = S_EMIT;
                end else if (i_sts.probe_last) begin
                    n_kind  = RES_FULL;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_SLOT_RD;
                end
            end
            S_REV_RD: begin
                o_cmd.key_rd     = 1'b1;
                o_cmd.key_rd_idx = 1'b1;
                n_kind           = RES_REV;
                n_state          = S_EMIT;
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.count_clear = 1'b1;
                    n_kind            = RES_ZERO;
                    n_state           = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/kdim_dp.sv @@
// ----------------------------------------------------------------------------
// kdim_dp
// Datapath: slot table, key store, hash, counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kdim_dp
    import kdim_pkg::*;
#(
    parameter int  CAPACITY   = 1024,
    parameter int  HASH_SLOTS = 2048,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_TW      = ((KEY_W + IDX_W + 7) / 8) * 8,
    localparam int OUT_TW     = ((IDX_W + KEY_W + 1 + ST_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IN_TW-1:0]  i_s_axis_tdata,
    input  wire logic              i_m_axis_tready,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic                   o_m_axis_tvalid,
    output logic [OUT_TW-1:0]      o_m_axis_tdata
);

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int PRB_W  = $clog2(HASH_SLOTS + 1);
    localparam logic [SLOT_W:0]   SLOTS_C   = (SLOT_W + 1)'(HASH_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);
    localparam logic [PRB_W-1:0]  LAST_PRB  = PRB_W'(HASH_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CAP_C     = CNT_W'(CAPACITY);

    // Storage: slot holds entry index + 1, zero means empty
    logic [CNT_W-1:0]        slot_mem [HASH_SLOTS];
    logic signed [KEY_W-1:0] key_mem  [CAPACITY];

    logic signed [KEY_W-1:0] w_in_key;
    logic [IDX_W-1:0]        w_in_idx;
    logic [KEY_W-1:0]        w_mix;
    logic [SLOT_W-1:0]       w_fold;
    logic [SLOT_W-1:0]       w_home;
    logic [IDX_W-1:0]        w_entry_idx;
    logic [IDX_W-1:0]        w_key_addr;

    logic signed [KEY_W-1:0] r_key;
    logic [IDX_W-1:0]        r_idx;
    logic [SLOT_W-1:0]       r_slot;
    logic [PRB_W-1:0]        r_probe;
    logic [CNT_W-1:0]        r_slot_q;
    logic signed [KEY_W-1:0] r_key_q;
    logic [CNT_W-1:0]        r_count;
    logic [SLOT_W-1:0]       r_clr_addr;

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_dense;
    logic signed [KEY_W-1:0] r_out_key;
    logic                    r_out_new;
    logic [ST_W-1:0]         r_out_status;
    logic [CNT_W-1:0]        r_out_count;

    logic [IDX_W-1:0]        n_out_dense;
    logic signed [KEY_W-1:0] n_out_key;
    logic                    n_out_new;
    logic [ST_W-1:0]         n_out_status;

    assign w_in_key    = i_s_axis_tdata[KEY_W-1:0];
    assign w_in_idx    = i_s_axis_tdata[KEY_W +: IDX_W];
    assign w_entry_idx = IDX_W'(r_slot_q - 1'b1);
    assign w_key_addr  = i_cmd.key_rd_idx ? r_idx : w_entry_idx;

    // Home slot: shift-xor mix folded down to the slot address width
    always_comb begin
        w_mix  = w_in_key ^ (w_in_key >> 33);
        w_fold = '0;
        for (int b = 0; b < KEY_W; b++) begin
            w_fold[b % SLOT_W] = w_fold[b % SLOT_W] ^ w_mix[b];
        end
        if ({1'b0, w_fold} >= SLOTS_C) begin
            w_home = SLOT_W'({1'b0, w_fold} - SLOTS_C);
        end else begin
            w_home = w_fold;
        end
    end

    // Request capture and probe position
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key   <= w_in_key;
            r_idx   <= w_in_idx;
            r_slot  <= w_home;
            r_probe <= '0;
        end else if (i_cmd.advance) begin
            r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_probe <= r_probe + 1'b1;
        end
    end

    // Slot table port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            slot_mem[r_clr_addr] <= '0;
        end else if (i_cmd.insert) begin
            slot_mem[r_slot] <= r_count + 1'b1;
        end
        if (i_cmd.slot_rd) begin
            r_slot_q <= slot_mem[r_slot];
        end
    end

    // Key store port
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            key_mem[r_count[IDX_W-1:0]] <= r_key;
        end else if (i_cmd.key_rd) begin
            r_key_q <= key_mem[w_key_addr];
        end
    end

    // Entry count and clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.count_clear) begin
                r_count <= '0;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= (r_clr_addr == LAST_SLOT) ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    // Status back to the sequencer
    always_comb begin
        o_sts.slot_empty = (r_slot_q == '0);
        o_sts.key_match  = (r_key_q == r_key);
        o_sts.table_full = (r_count >= CAP_C);
        o_sts.probe_last = (r_probe == LAST_PRB);
        o_sts.idx_ok     = (CNT_W'(w_in_idx) < r_count);
        o_sts.clr_last   = (r_clr_addr == LAST_SLOT);
        o_sts.out_busy   = r_out_valid && !i_m_axis_tready;
    end

    // Result word assembly
    always_comb begin
        n_out_dense  = '0;
        n_out_key    = '0;
        n_out_new    = 1'b0;
        n_out_status = ST_OK;
        case (i_cmd.kind)
            RES_HIT: begin
                n_out_dense = w_entry_idx;
                n_out_key   = r_key;
            end
            RES_NEW: begin
                n_out_dense = IDX_W'(r_count - 1'b1);
                n_out_key   = r_key;
                n_out_new   = 1'b1;
            end
            RES_FULL: begin
                n_out_key    = r_key;
                n_out_status = ST_FULL;
            end
            RES_REV: begin
                n_out_dense = r_idx;
                n_out_key   = r_key_q;
            end
            RES_BADIDX: begin
                n_out_dense  = r_idx;
                n_out_status = ST_UNASSIGNED;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_dense  <= n_out_dense;
            r_out_key    <= n_out_key;
            r_out_new    <= n_out_new;
            r_out_status <= n_out_status;
            r_out_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'({r_out_count, r_out_status, r_out_new,
                                      r_out_key, r_out_dense});

endmodule

`default_nettype wire

@@ rtl/kdim_checker.sv @@
// ----------------------------------------------------------------------------
// kdim_checker
// Port-level checks on the result stream of the key map.
// ----------------------------------------------------------------------------
`default_nettype none

module kdim_checker
    import kdim_pkg::*;
#(
    parameter int  CAPACITY = 1024,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int OUT_TW   = ((IDX_W + KEY_W + 1 + ST_W + CNT_W + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_TW-1:0] m_axis_tdata
);

    localparam int NEW_B = IDX_W + KEY_W;
    localparam int ST_LO = NEW_B + 1;
    localparam int CN_LO = ST_LO + ST_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [ST_W-1:0]  w_status;
    logic [CNT_W-1:0] w_count;
    logic             w_new;

    assign w_status = m_axis_tdata[ST_LO +: ST_W];
    assign w_count  = m_axis_tdata[CN_LO +: CNT_W];
    assign w_new    = m_axis_tdata[NEW_B];

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word does not change
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Status is never the unused code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status == ST_OK || w_status == ST_FULL ||
                           w_status == ST_UNASSIGNED))
        else $error("bad status code");

    // A fresh index means success and a nonzero count
    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_new |-> (w_status == ST_OK && w_count != '0))
        else $error("new entry with bad status or count");

    // Count never exceeds capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= CAP_C))
        else $error("entry count above capacity");

endmodule

bind key_to_dense_index_map kdim_checker #(
    .CAPACITY (CAPACITY)
) u_kdim_checker (.*);

`default_nettype wire

@@ tb/kdim_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdim_scoreboard
// Scoreboard for the key to dense index map.
// ----------------------------------------------------------------------------
// Watches both stream channels. Each accepted request word runs through a
// behavioral model of the map (key lookup, in-order index assignment, reverse
// lookup, clear), and the predicted result word is queued. Each accepted
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module kdim_scoreboard
    import kdim_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // key, index
    input  wire logic [79:0] i_s_tdata,
    // opcode
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // dense_index, sparse_key, was_new, status, entry_count
    input  wire logic [87:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);

    localparam int CAP = 1024;

    // Packed from the top bit down: entry_count ends up in the highest bits
    typedef struct packed {
        logic [10:0] entry_count;
        logic [1:0]  status;
        logic        was_new;
        logic [63:0] sparse_key;
        logic [9:0]  dense_index;
    } t_map_result;

    // Model state: key lookup, key per index, assigned count
    int unsigned  index_of_key [logic [63:0]];
    logic [63:0]  key_at_index [CAP];
    int unsigned  assigned;
    t_map_result  expected_words [$];
    int           errors;

    assign o_errors  = errors;
    assign o_pending = expected_words.size();

    function automatic t_map_result map_request(logic [1:0] op, logic [63:0] key,
                                                logic [9:0] idx);
        t_map_result r;
        r = '0;
        if (op == OP_MAP) begin
            r.sparse_key = key;
            if (index_of_key.exists(key)) begin
                r.dense_index = 10'(index_of_key[key]);
            end else if (assigned >= CAP) begin
                r.status = ST_FULL;
            end else begin
                index_of_key[key]      = assigned;
                key_at_index[assigned] = key;
                r.dense_index          = 10'(assigned);
                r.was_new              = 1'b1;
                assigned               = assigned + 1;
            end
            r.entry_count = 11'(assigned);
        end else if (op == OP_REV) begin
            r.dense_index = idx;
            if (idx < assigned) begin
                r.sparse_key = key_at_index[idx];
            end else begin
                r.status = ST_UNASSIGNED;
            end
            r.entry_count = 11'(assigned);
        end else if (op == OP_CLEAR) begin
            index_of_key.delete();
            assigned = 0;
        end else begin
            // undefined opcode: state kept, only the count is reported
            r.entry_count = 11'(assigned);
        end
        return r;
    endfunction

    // Predict on request accept, compare on result accept
    always @(posedge i_clk) begin
        t_map_result got;
        t_map_result want;
        if (!i_rst_n) begin
            index_of_key.delete();
            assigned = 0;
            expected_words.delete();
            errors = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_words = {expected_words,
                                  map_request(i_s_tuser, i_s_tdata[63:0],
                                              i_s_tdata[73:64])};
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[87:0];
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_m_tdata);
                    errors = errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.dense_index !== want.dense_index) begin
                        $display("%0t: dense_index exp %0d got %0d", $time,
                                 want.dense_index, got.dense_index);
                        errors = errors + 1;
                    end
                    if (got.sparse_key !== want.sparse_key) begin
                        $display("%0t: sparse_key exp %h got %h", $time,
                                 want.sparse_key, got.sparse_key);
                        errors = errors + 1;
                    end
                    if (got.was_new !== want.was_new) begin
                        $display("%0t: was_new exp %0b got %0b", $time,
                                 want.was_new, got.was_new);
                        errors = errors + 1;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time,
                                 want.status, got.status);
                        errors = errors + 1;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count exp %0d got %0d", $time,
                                 want.entry_count, got.entry_count);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_key_to_dense_index_map.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_to_dense_index_map
// Stimulus and verdict for the key to dense index map.
// ----------------------------------------------------------------------------
// Directed words hit the key extremes, hits, reverse lookups in and out of
// range, the undefined opcode and clear. Random phases then mix repeated and
// fresh keys with reverse lookups and rare clears, and a fill runs to full
// capacity; random source and sink stalls take two settings, then none.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_key_to_dense_index_map
    import kdim_pkg::*;
();

    // Opcode with no defined operation
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;    // key, index
    logic [1:0]  s_axis_tuser;    // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;    // dense_index, sparse_key, was_new, status, entry_count
    int          errors;
    int          pending;

    int unsigned src_idle;
    int unsigned snk_idle;
    logic [63:0] used_keys [$];

    key_to_dense_index_map dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kdim_scoreboard scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("key_to_dense_index_map test failed");
        $finish;
    end

    // Sink stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    // One request word; optional source gap before it
    task automatic send_word(logic [1:0] op, logic [63:0] key, logic [9:0] idx);
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, idx, key};
        if (op == OP_MAP)
            used_keys = {used_keys, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [63:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly map requests on repeated and fresh keys, some reverse lookups
    task automatic random_words(int n);
        int          roll;
        logic [63:0] k;
        logic [9:0]  ix;
        repeat (n) begin
            roll = $urandom_range(99);
            ix   = 10'($urandom);
            if (roll < 30 && used_keys.size() > 0)
                send_word(OP_MAP, used_keys[$urandom_range(used_keys.size() - 1)],
                          ix);
            else if (roll < 60)
                send_word(OP_MAP, fresh_key(), ix);
            else if (roll < 80)
                send_word(OP_REV, fresh_key(), ix % 64);
            else if (roll < 95)
                send_word(OP_REV, fresh_key(), ix);
            else if (roll < 98) begin
                k = fresh_key();
                send_word(OP_UNUSED, k, ix);
            end else
                send_word(OP_CLEAR, fresh_key(), ix);
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_MAP;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        src_idle      = 21;
        snk_idle      = 73;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key extremes, hits, reverse in and out of range
        send_word(OP_MAP, 64'h8000_0000_0000_0000, 10'd0);
        send_word(OP_MAP, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0);
        send_word(OP_MAP, 64'h0, 10'h3FF);
        send_word(OP_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        send_word(OP_MAP, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0);
        send_word(OP_MAP, 64'h8000_0000_0000_0000, 10'd0);
        send_word(OP_MAP, 64'h0, 10'd0);
        send_word(OP_REV, 64'h0, 10'd0);
        send_word(OP_REV, 64'h0, 10'd3);
        send_word(OP_REV, 64'h0, 10'd4);
        send_word(OP_REV, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
        send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
        send_word(OP_CLEAR, 64'h0, 10'd0);
        send_word(OP_REV, 64'h0, 10'd0);
        send_word(OP_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        send_word(OP_MAP, 64'h1, 10'd0);
        send_word(OP_REV, 64'h0, 10'd1);
        send_word(OP_REV, 64'h0, 10'd2);

        random_words(175);
        src_idle = 73;
        snk_idle = 21;
        random_words(175);
        src_idle = 0;
        snk_idle = 0;

        // Fill to capacity, then probe the full table
        send_word(OP_CLEAR, 64'h0, 10'd0);
        repeat (1030) send_word(OP_MAP, fresh_key(), 10'd0);
        repeat (10) send_word(OP_MAP, fresh_key(), 10'd0);
        repeat (10) send_word(OP_MAP, used_keys[$urandom_range(used_keys.size() - 1)],
                              10'd0);
        send_word(OP_REV, 64'h0, 10'h3FF);
        send_word(OP_REV, 64'h0, 10'd0);
        random_words(40);
        send_word(OP_CLEAR, 64'h0, 10'd0);
        random_words(150);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (errors == 0)
            $display("key_to_dense_index_map test passed");
        else
            $display("key_to_dense_index_map test failed");
        $finish;
    end

endmodule

`default_nettype wire
